[hw/rtl/u8dec_pkg.sv]
// Shared widths, reset values and lead byte tags of the UTF-8 byte stream decoder.
// No dependencies. Used by the top level and its assertion checker.
package u8dec_pkg;

    localparam int BYTE_W   = 8;
    localparam int SYMBOL_W = 32;
    localparam int SEEN_W   = 2;
    localparam int COLL_W   = 12;
    localparam int PAY_W    = 6;
    // Widest code point the decoder can build: 3 lead bits and 18 payload bits.
    localparam int CODE_W   = 21;

    localparam logic [SYMBOL_W-1:0] ERROR_VALUE_RST = 32'd65533;

    // Bytes of the open sequence read so far.
    localparam logic [SEEN_W-1:0] SEEN_NONE  = 2'd0;
    localparam logic [SEEN_W-1:0] SEEN_ONE   = 2'd1;
    localparam logic [SEEN_W-1:0] SEEN_TWO   = 2'd2;
    localparam logic [SEEN_W-1:0] SEEN_THREE = 2'd3;

    // Top bits of the lead and continuation byte classes.
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

endpackage

[hw/rtl/utf8_byte_stream_decode_top.sv]
// UTF-8 byte stream decoder, top level: input register, decode logic, result register.
// Depends on u8dec_pkg.
//
// Usage:
//   Input channel: one text byte per beat (i_text_byte, i_final_byte) on
//   i_in_valid / o_in_stall. Output channel: at most one decoded symbol per
//   input beat (o_symbol, o_is_error, o_text_done) on o_out_valid /
//   i_out_stall. Bytes that only continue an open sequence give no result.
//   Config channel: i_cfg_valid / o_cfg_ready writes the error value; ready is
//   always high. Write it only while no bytes are in flight.
//   Throughput: one byte per cycle while no result is stalled. The decode of a
//   byte depends on the state left by the previous one only through a single
//   register update, so a byte enters every cycle unless i_out_stall holds a result.
//   Path: an accepted byte is held in the input register, then its result is
//   loaded into the result register, from which the output channel takes it.
//   Stall: while a result waits under i_out_stall, the input register still
//   takes one more byte; o_in_stall rises only once that byte is held too.
//   Reset: no sequence open, no beats held, error value 0xFFFD.
module utf8_byte_stream_decode_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input bytes
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [u8dec_pkg::BYTE_W-1:0]   i_text_byte,
    input  logic                           i_final_byte,
    // decoded symbols
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [u8dec_pkg::SYMBOL_W-1:0] o_symbol,
    output logic                           o_is_error,
    output logic                           o_text_done,
    // error value register
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [u8dec_pkg::SYMBOL_W-1:0] i_cfg_data
);

    logic [u8dec_pkg::SYMBOL_W-1:0] r_error_value;

    logic                           r_in_valid;
    logic [u8dec_pkg::BYTE_W-1:0]   r_in_byte;
    logic                           r_in_final;

    logic [u8dec_pkg::BYTE_W-1:0]   r_lead, n_lead;
    logic [u8dec_pkg::SEEN_W-1:0]   r_seen, n_seen;
    logic [u8dec_pkg::COLL_W-1:0]   r_coll, n_coll;

    logic                           r_out_valid;
    logic [u8dec_pkg::SYMBOL_W-1:0] r_symbol, n_symbol;
    logic                           r_is_error, n_is_error;
    logic                           r_text_done;
    logic                           n_emit;

    logic                           advance;
    logic                           in_accept;
    logic [u8dec_pkg::PAY_W-1:0]    pay;

    assign advance   = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && !o_in_stall;
    assign pay       = r_in_byte[u8dec_pkg::PAY_W-1:0];

    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_is_error  = r_is_error;
    assign o_text_done = r_text_done;

    // Decode of the held byte against the open sequence.
    always_comb begin
        n_lead     = r_lead;
        n_seen     = r_seen;
        n_coll     = r_coll;
        n_emit     = 1'b0;
        n_symbol   = r_error_value;
        n_is_error = 1'b1;

        if (r_seen == u8dec_pkg::SEEN_NONE) begin
            if (!r_in_byte[7]) begin
                n_emit     = 1'b1;
                n_symbol   = {{(u8dec_pkg::SYMBOL_W-u8dec_pkg::BYTE_W){1'b0}}, r_in_byte};
                n_is_error = 1'b0;
            end else begin
                n_lead = r_in_byte;
                n_seen = u8dec_pkg::SEEN_ONE;
                n_emit = r_in_final;
            end
        end else if (r_in_byte[7:6] != u8dec_pkg::CONT_TAG) begin
            n_emit = 1'b1;
        end else begin
            unique case (r_seen)
                u8dec_pkg::SEEN_ONE: begin
                    if (r_lead[7:5] == u8dec_pkg::LEAD2_TAG) begin
                        n_emit     = 1'b1;
                        n_symbol   = {21'd0, r_lead[4:0], pay};
                        n_is_error = 1'b0;
                    end else begin
                        n_coll = {{(u8dec_pkg::COLL_W-u8dec_pkg::PAY_W){1'b0}}, pay};
                        n_seen = u8dec_pkg::SEEN_TWO;
                        n_emit = r_in_final;
                    end
                end
                u8dec_pkg::SEEN_TWO: begin
                    if (r_lead[7:4] == u8dec_pkg::LEAD3_TAG) begin
                        n_emit     = 1'b1;
                        n_symbol   = {16'd0, r_lead[3:0], r_coll[5:0], pay};
                        n_is_error = 1'b0;
                    end else begin
                        n_coll = {r_coll[5:0], pay};
                        n_seen = u8dec_pkg::SEEN_THREE;
                        n_emit = r_in_final;
                    end
                end
                u8dec_pkg::SEEN_THREE: begin
                    n_emit = 1'b1;
                    if (r_lead[7:3] == u8dec_pkg::LEAD4_TAG) begin
                        n_symbol   = {11'd0, r_lead[2:0], r_coll, pay};
                        n_is_error = 1'b0;
                    end
                end
                default: begin
                    n_emit = 1'b1;
                end
            endcase
        end

        // Any result closes the sequence.
        if (n_emit) begin
            n_lead = '0;
            n_seen = u8dec_pkg::SEEN_NONE;
            n_coll = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_value <= u8dec_pkg::ERROR_VALUE_RST;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_lead        <= '0;
            r_seen        <= u8dec_pkg::SEEN_NONE;
            r_coll        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_error_value <= i_cfg_data;
            end

            if (in_accept) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_text_byte;
                r_in_final <= i_final_byte;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= r_in_valid && n_emit;
                if (r_in_valid) begin
                    r_lead      <= n_lead;
                    r_seen      <= n_seen;
                    r_coll      <= n_coll;
                    r_symbol    <= n_symbol;
                    r_is_error  <= n_is_error;
                    r_text_done <= r_in_final;
                end
            end
        end
    end

endmodule

[hw/rtl/u8dec_checker.sv]
// Port-level assertions for the UTF-8 byte stream decoder, bound to its top level.
// Depends on u8dec_pkg and utf8_byte_stream_decode_top.
module u8dec_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [u8dec_pkg::SYMBOL_W-1:0] o_symbol,
    input logic                           o_is_error,
    input logic                           o_text_done
);

    // A waiting result keeps its beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_symbol)
            && $stable(o_is_error) && $stable(o_text_done))
        else $error("stalled result changed");

    // Input backs up only behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

    // A decoded code point never exceeds 21 bits.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_error
            |-> o_symbol[u8dec_pkg::SYMBOL_W-1:u8dec_pkg::CODE_W] == '0)
        else $error("decoded symbol out of range");

    // Nothing in flight right after reset: no result is valid and the input is not stalled.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("beat held across reset");

endmodule

bind utf8_byte_stream_decode_top u8dec_checker u_u8dec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_symbol    (o_symbol),
    .o_is_error  (o_is_error),
    .o_text_done (o_text_done)
);
